// ===== src/sgm_pkg.sv =====
// shared constants, types and the absolute-value function for the gradient block
// no dependencies
package sgm_pkg;
   localparam int unsigned DefMaxWidth = 2048;
   localparam logic [11:0] RstWidth  = 12'd640;
   localparam logic [15:0] RstHeight = 16'd480;
   localparam logic [16:0] SumClamp  = 17'd65025;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_CHAN   = 2'd2,
      CSR_ROUND  = 2'd3
   } csr_idx_type;

   // one column of the window: up, mid, down sample of one channel
   typedef struct packed {
      logic [7:0] up;
      logic [7:0] mid;
      logic [7:0] dn;
   } col_type;

   // absolute value of one signed gradient
   function automatic logic [9:0] abs11(input logic signed [10:0] v);
      logic signed [10:0] n;
      n = -v;
      return v[10] ? n[9:0] : v[9:0];
   endfunction
endpackage

// ===== src/sgm_root.sv =====
// pipelined square root of one 17-bit sum, saturated to 8 bits
// depends on sgm_pkg
module sgm_root (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [16:0] sum,
   input  logic        round_nearest,
   input  logic        advance,
   output logic [7:0]  mag
);
   // nine restoring steps, one per stage, each two bits of the radicand
   localparam int Steps = 9;
   logic [17:0] rem_ff [0:Steps];
   logic [17:0] src_ff [0:Steps];
   logic [8:0]  res_ff [0:Steps];
   logic        rnd_ff [0:Steps];
   logic [8:0]  fin;
   logic [8:0]  rnd_res;
   logic [17:0] chk;

   always_comb begin
      rem_ff[0] = 18'd0;
      res_ff[0] = 9'd0;
      rnd_ff[0] = round_nearest;
      if (round_nearest && sum > sgm_pkg::SumClamp) begin
         src_ff[0] = {1'b0, sgm_pkg::SumClamp};
      end else begin
         src_ff[0] = {1'b0, sum};
      end
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [17:0] trial;
      logic [17:0] rem_n;
      assign rem_n = {rem_ff[s][15:0], src_ff[s][17:16]};
      assign trial = {7'd0, res_ff[s], 2'b01};
      always_ff @(posedge clock) begin
         if (advance) begin
            src_ff[s+1] <= {src_ff[s][15:0], 2'b00};
            rnd_ff[s+1] <= rnd_ff[s];
            if (rem_n >= trial) begin
               rem_ff[s+1] <= rem_n - trial;
               res_ff[s+1] <= {res_ff[s][7:0], 1'b1};
            end else begin
               rem_ff[s+1] <= rem_n;
               res_ff[s+1] <= {res_ff[s][7:0], 1'b0};
            end
         end
      end
   end

   // remainder > root means sum > root*root + root
   assign chk = {9'd0, res_ff[Steps]};
   assign rnd_res = (rnd_ff[Steps] && rem_ff[Steps] > chk) ?
                    res_ff[Steps] + 9'd1 : res_ff[Steps];
   assign fin = rnd_res;
   assign mag = fin[8] ? 8'hFF : fin[7:0];

   logic unused;
   assign unused = in_valid ^ reset;
endmodule

// ===== src/sobel_gradient_magnitude.sv =====
// sobel gradient magnitude over a raster stream with replicated borders
// depends on sgm_pkg and sgm_root
//
//  channel | direction | handshake   | payload
//  req_    | in        | valid/stall | req_type, sample_0..2
//  rsp_    | out       | valid/stall | mag_0..2, out_row, out_col, last_in_run, frame_done
//  csr_    | in        | valid/ready | index, data
//
// one request is worked at a time: line read, window, sums and write-back, square root
// pipe, one response at a time, then back to idle to take the next request. a pixel
// gives one, two or no responses; a drain tick does three line reads. the root pipe
// and line store access set this pace.
// reset is synchronous and clears counters and the window; line stores are not cleared.
// a stalled response holds until taken.
module sobel_gradient_magnitude (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_sample_0,
   input  logic [7:0]  req_sample_1,
   input  logic [7:0]  req_sample_2,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_mag_0,
   output logic [7:0]  rsp_mag_1,
   output logic [7:0]  rsp_mag_2,
   output logic [15:0] rsp_out_row,
   output logic [10:0] rsp_out_col,
   output logic        rsp_last_in_run,
   output logic        rsp_frame_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int unsigned MaxWidth = sgm_pkg::DefMaxWidth;
   localparam int AW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
   localparam int WW = $clog2(MaxWidth + 1);
   localparam int PipeLen = 10;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_RD1, S_RD2, S_RD3, S_CALC, S_ROOT, S_OUT
   } state_type;

   logic [11:0] width_ff;
   logic [15:0] height_ff;
   logic        chan_ff, round_ff;

   // line stores: upper and middle rows, 3 samples each
   logic [23:0] upper_mem [0:MaxWidth-1];
   logic [23:0] middle_mem [0:MaxWidth-1];
   logic [23:0] up_rd_ff, mid_rd_ff;
   logic        we;
   logic [AW-1:0] wa, ra;
   logic [23:0] up_wd, mid_wd;

   always_ff @(posedge clock) begin
      if (we) begin
         upper_mem[wa]  <= up_wd;
         middle_mem[wa] <= mid_wd;
      end
      up_rd_ff  <= upper_mem[ra];
      mid_rd_ff <= middle_mem[ra];
   end

   state_type   state_ff;
   logic [10:0] col_ff;
   logic [15:0] row_ff;
   logic [11:0] drain_ff;
   logic        type_ff;
   logic [23:0] pix_ff;
   logic [AW-1:0] x_ff, lx_ff, rx_ff;
   logic        end_ff, first_ff, done_ff;
   logic [1:0]  nout_ff, oidx_ff;
   logic [3:0]  cnt_ff;
   logic [15:0] orow_ff;
   logic [10:0] ocol_ff;
   // window: three columns, three channels
   sgm_pkg::col_type win_ff [0:2][0:2];
   sgm_pkg::col_type ld_ff [0:2][0:2]; // drain columns: 1 left, 0 right
   logic [16:0] sum_ff [0:1][0:2];
   logic [7:0]  mag_ff [0:1][0:2];
   logic        adv;

   // effective width and height
   logic [WW-1:0] w_eff;
   logic [15:0]   h_eff;
   always_comb begin
      if (width_ff == 12'd0) w_eff = WW'(1);
      else if ({20'd0, width_ff} > 32'(MaxWidth)) w_eff = WW'(MaxWidth);
      else w_eff = WW'(width_ff);
      h_eff = (height_ff == 16'd0) ? 16'd1 : height_ff;
   end
   logic [WW-1:0] wm1;
   assign wm1 = w_eff - WW'(1);

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sgm_pkg::RstWidth;
         height_ff <= sgm_pkg::RstHeight;
         chan_ff <= 1'b0;
         round_ff <= 1'b1;
      end else if (csr_valid) begin
         case (sgm_pkg::csr_idx_type'(csr_index))
            sgm_pkg::CSR_WIDTH:  width_ff <= csr_data[11:0];
            sgm_pkg::CSR_HEIGHT: height_ff <= csr_data;
            sgm_pkg::CSR_CHAN:   chan_ff <= csr_data[0];
            sgm_pkg::CSR_ROUND:  round_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   logic acc;
   assign acc = req_valid && !req_stall;

   // gradient sum of one channel from three columns
   function automatic logic [16:0] gsum(input sgm_pkg::col_type l, input sgm_pkg::col_type c,
                                        input sgm_pkg::col_type r);
      logic signed [10:0] gx, gy;
      logic [9:0] ax, ay;
      logic [20:0] sq;
      gx = $signed({3'd0, l.up}) - $signed({3'd0, r.up})
         + ($signed({3'd0, l.mid}) - $signed({3'd0, r.mid})) * 11'sd2
         + $signed({3'd0, l.dn}) - $signed({3'd0, r.dn});
      gy = $signed({3'd0, l.up}) + $signed({3'd0, r.up})
         + ($signed({3'd0, c.up}) - $signed({3'd0, c.dn})) * 11'sd2
         - $signed({3'd0, l.dn}) - $signed({3'd0, r.dn});
      ax = sgm_pkg::abs11(gx);
      ay = sgm_pkg::abs11(gy);
      sq = 21'(ax * ax) + 21'(ay * ay);
      return (sq > 21'h1FFFF) ? 17'h1FFFF : sq[16:0];
   endfunction

   // memory address and write control
   logic [WW-1:0] cur_x, dd;
   always_comb begin
      cur_x = ({5'd0, col_ff} >= 16'(w_eff)) ? wm1 : WW'(col_ff);
      dd = ({4'd0, drain_ff} >= 16'(w_eff)) ? wm1 : WW'(drain_ff);
      ra = x_ff;
      case (state_ff)
         S_RD1: ra = lx_ff;
         S_RD2: ra = rx_ff;
         default: ra = x_ff;
      endcase
      we = (state_ff == S_CALC) && !type_ff;
      wa = x_ff;
      up_wd  = first_ff ? pix_ff : mid_rd_ff;
      mid_wd = pix_ff;
   end

   function automatic sgm_pkg::col_type mkcol(input logic [23:0] u, input logic [23:0] m,
                                              input logic [23:0] d, input int ch);
      sgm_pkg::col_type c;
      c.up = u[ch*8 +: 8];
      c.mid = m[ch*8 +: 8];
      c.dn = d[ch*8 +: 8];
      return c;
   endfunction

   // root pipes: two results x three channels
   logic [7:0] root_o [0:1][0:2];
   for (genvar k = 0; k < 2; k++) begin : g_k
      for (genvar c = 0; c < 3; c++) begin : g_c
         sgm_root u_root (
            .clock(clock), .reset(reset), .in_valid(adv), .sum(sum_ff[k][c]),
            .round_nearest(round_ff), .advance(adv), .mag(root_o[k][c])
         );
      end
   end
   assign adv = (state_ff == S_ROOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff <= '0;
         row_ff <= '0;
         drain_ff <= '0;
         cnt_ff <= '0;
         oidx_ff <= '0;
         nout_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) win_ff[i][c] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  type_ff <= req_type;
                  pix_ff <= {req_sample_2, req_sample_1, req_sample_0};
                  if (req_type) begin
                     if (row_ff >= h_eff) begin
                        x_ff <= AW'(dd);
                        lx_ff <= (dd == '0) ? '0 : AW'(dd - WW'(1));
                        rx_ff <= (dd + WW'(1) < w_eff) ? AW'(dd + WW'(1)) : AW'(wm1);
                        done_ff <= (dd + WW'(1) >= w_eff);
                        orow_ff <= h_eff - 16'd1;
                        ocol_ff <= 11'(dd);
                        state_ff <= S_RD1;
                     end
                  end else if (row_ff < h_eff) begin
                     x_ff <= AW'(cur_x);
                     end_ff <= (cur_x + WW'(1) >= w_eff);
                     first_ff <= (row_ff == 16'd0);
                     orow_ff <= row_ff - 16'd1;
                     ocol_ff <= 11'(cur_x);
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               // read of x is in flight; the stores are written back in calc
               state_ff <= S_CALC;
            end
            S_RD1: state_ff <= S_RD2;
            S_RD2: begin
               for (int c = 0; c < 3; c++)
                  ld_ff[1][c] <= mkcol(up_rd_ff, mid_rd_ff, mid_rd_ff, c);
               state_ff <= S_RD3;
            end
            S_RD3: begin
               for (int c = 0; c < 3; c++)
                  ld_ff[0][c] <= mkcol(up_rd_ff, mid_rd_ff, mid_rd_ff, c);
               state_ff <= S_CALC;
            end
            S_CALC: begin
               cnt_ff <= '0;
               oidx_ff <= '0;
               if (type_ff) begin
                  for (int c = 0; c < 3; c++) begin
                     sum_ff[0][c] <= gsum(ld_ff[1][c],
                                          mkcol(up_rd_ff, mid_rd_ff, mid_rd_ff, c),
                                          ld_ff[0][c]);
                     sum_ff[1][c] <= '0;
                  end
                  nout_ff <= 2'd1;
                  state_ff <= S_ROOT;
               end else begin
                  if (end_ff) begin
                     col_ff <= '0;
                     row_ff <= row_ff + 16'd1;
                  end else begin
                     col_ff <= 11'(x_ff) + 11'd1;
                  end
                  if (first_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     for (int c = 0; c < 3; c++) begin
                        sgm_pkg::col_type nc;
                        nc = mkcol(up_rd_ff, mid_rd_ff, pix_ff, c);
                        if (x_ff == '0) begin
                           win_ff[0][c] <= nc;
                           win_ff[1][c] <= nc;
                           win_ff[2][c] <= nc;
                           sum_ff[0][c] <= gsum(nc, nc, nc);
                           sum_ff[1][c] <= gsum(nc, nc, nc);
                        end else begin
                           win_ff[0][c] <= win_ff[1][c];
                           win_ff[1][c] <= win_ff[2][c];
                           win_ff[2][c] <= nc;
                           sum_ff[0][c] <= gsum(win_ff[1][c], win_ff[2][c], nc);
                           sum_ff[1][c] <= gsum(win_ff[2][c], nc, nc);
                        end
                     end
                     if (x_ff != '0 && end_ff) begin
                        nout_ff <= 2'd2;
                        ocol_ff <= ocol_ff - 11'd1;
                     end else if (x_ff != '0) begin
                        nout_ff <= 2'd1;
                        ocol_ff <= ocol_ff - 11'd1;
                     end else begin
                        nout_ff <= end_ff ? 2'd1 : 2'd0;
                        oidx_ff <= 2'd1;
                     end
                     state_ff <= (x_ff != '0 || end_ff) ? S_ROOT : S_IDLE;
                  end
               end
            end
            S_ROOT: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(PipeLen - 1)) begin
                  for (int k = 0; k < 2; k++) begin
                     for (int c = 0; c < 3; c++)
                        mag_ff[k][c] <= chan_ff || c == 0 ? root_o[k][c] : 8'd0;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  if (rsp_last_in_run) begin
                     state_ff <= S_IDLE;
                     if (type_ff) begin
                        if (done_ff) begin
                           col_ff <= '0;
                           row_ff <= '0;
                           drain_ff <= '0;
                        end else begin
                           drain_ff <= 12'(x_ff) + 12'd1;
                        end
                     end
                  end else begin
                     oidx_ff <= oidx_ff + 2'd1;
                     ocol_ff <= ocol_ff + 11'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic sel;
   assign sel = oidx_ff[0];
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_mag_0 = mag_ff[sel][0];
   assign rsp_mag_1 = mag_ff[sel][1];
   assign rsp_mag_2 = mag_ff[sel][2];
   assign rsp_out_row = orow_ff;
   assign rsp_out_col = ocol_ff;
   assign rsp_last_in_run = type_ff || !end_ff || sel || (nout_ff == 2'd1);
   assign rsp_frame_done = type_ff && done_ff;

   logic unused;
   assign unused = ^{cnt_ff[3], oidx_ff[1]};

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_col))
      else $error("response dropped under stall");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_in_run) else $error("frame end not last");
endmodule
